// File: rtl/dltq_pkg.sv
package dltq_pkg;
  localparam int NUM_TIMERS_DEF = 16;
  localparam int DELTA_W = 31;
  localparam int ID_W = 16;
  localparam int ARG_W = 32;
  localparam int MAX_OUT = 16;

  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EXPIRED  = 3'd4;
  localparam logic [2:0] ST_NONE     = 3'd5;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [DELTA_W-1:0] delay_ticks;
    logic [ID_W-1:0]    callback_id;
    logic [ARG_W-1:0]   callback_arg;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [ID_W-1:0]  expired_id;
    logic [ARG_W-1:0] expired_arg;
    logic             last;
  } result_item_t;
endpackage

// File: rtl/dltq_if.sv
interface dltq_cmd_if;
  import dltq_pkg::*;
  logic      valid;
  logic      ready;
  cmd_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dltq_res_if;
  import dltq_pkg::*;
  logic         valid;
  logic         ready;
  result_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/delta_list_timer_queue.sv
// Delta-list timer queue.
// in: one command per transfer (set, cancel, tick) with delay, handler id and
// argument. out: one result per set/cancel/unknown command; a tick gives one
// result per expired entry (up to 16) or one "nothing expired" result; the
// final result of each command carries last = 1.
// A single sequencer walks the linked list one entry per cycle while out is not
// stalled; the set walk's add-and-compare and the cancel fixup share one adder.
// After the accepting cycle a set passes through its walk, link and fix states, a
// cancel through its walk and fix states, a tick through head decrement and emit;
// in is not ready while a command is in progress or a result is waiting.
// Results sit in an output register; when out is stalled the sequencer
// holds until the result is transferred, so nothing is dropped.
// Reset (synchronous, active low) empties the pending list and rebuilds the
// free chain: a clearing pass over all NUM_TIMERS entries during which in is not
// ready.
module delta_list_timer_queue #(
  parameter int NUM_TIMERS = dltq_pkg::NUM_TIMERS_DEF
) (
  input logic clk,
  input logic rst_n,
  dltq_cmd_if.sink in_ch,
  dltq_res_if.source out_ch
);
  import dltq_pkg::*;

  localparam int IW = $clog2(NUM_TIMERS + 1);
  localparam int AW = $clog2(NUM_TIMERS);
  localparam logic [IW-1:0] NIL = IW'(NUM_TIMERS);
  localparam logic [DELTA_W-1:0] DMAX = {DELTA_W{1'b1}};

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_SWALK = 4'd2,
    S_SLINK = 4'd3, S_SFIX = 4'd4, S_CWALK = 4'd5, S_CFIX = 4'd6,
    S_THEAD = 4'd7, S_TEMIT = 4'd8;

  logic [IW-1:0]      link_r [NUM_TIMERS];
  logic [DELTA_W-1:0] delta_r [NUM_TIMERS];
  logic [ID_W-1:0]    hand_r [NUM_TIMERS];
  logic [ARG_W-1:0]   argm_r [NUM_TIMERS];

  logic [3:0]   state_r;
  logic [IW-1:0] head_r, free_r, p_r, q_r, r_r, bef_r;
  logic [IW:0]  steps_r;
  logic [4:0]   nout_r;
  logic [DELTA_W:0] total_r;
  cmd_item_t    cmd_r;
  result_item_t res_r;
  logic         ovalid_r;

  function automatic logic ok(input logic [IW-1:0] i);
    return i < NIL;
  endfunction

  wire [AW-1:0] ri = r_r[AW-1:0];
  wire [AW-1:0] hi = head_r[AW-1:0];
  wire [DELTA_W:0] add_sum = total_r + {1'b0, delta_r[ri]};
  wire out_busy = ovalid_r && !out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = res_r;

  function automatic result_item_t mk(input logic [2:0] s, input logic [ID_W-1:0] id,
                                      input logic [ARG_W-1:0] a, input logic l);
    result_item_t x;
    x.status = s; x.expired_id = id; x.expired_arg = a; x.last = l;
    return x;
  endfunction

  always_ff @(posedge clk) begin : seq_p
    logic emit_v;
    emit_v = 1'b0;
    if (!rst_n) begin
      state_r <= S_INIT;
      head_r <= NIL;
      free_r <= '0;
      p_r <= '0;
    end else if (!out_busy) begin
      case (state_r)
        S_INIT: begin
          link_r[p_r[AW-1:0]] <= p_r + 1'b1;
          p_r <= p_r + 1'b1;
          if (p_r == NIL - 1'b1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && !ovalid_r) begin
            cmd_r <= in_ch.data;
            steps_r <= '0;
            bef_r <= NIL;
            r_r <= head_r;
            case (in_ch.data.cmd)
              CMD_SET: begin
                if (in_ch.data.callback_id == '0 || in_ch.data.delay_ticks == '0) begin
                  res_r <= mk(ST_REJECTED, '0, '0, 1'b1); emit_v = 1'b1;
                end else if (!ok(free_r)) begin
                  res_r <= mk(ST_FULL, '0, '0, 1'b1); emit_v = 1'b1;
                end else begin
                  p_r <= free_r;
                  free_r <= link_r[free_r[AW-1:0]];
                  hand_r[free_r[AW-1:0]] <= in_ch.data.callback_id;
                  argm_r[free_r[AW-1:0]] <= in_ch.data.callback_arg;
                  q_r <= NIL;
                  total_r <= '0;
                  state_r <= S_SWALK;
                end
              end
              CMD_CANCEL: state_r <= S_CWALK;
              CMD_TICK: begin
                nout_r <= '0;
                if (!ok(head_r)) begin
                  res_r <= mk(ST_NONE, '0, '0, 1'b1); emit_v = 1'b1;
                end else state_r <= S_THEAD;
              end
              default: begin
                res_r <= mk(ST_REJECTED, '0, '0, 1'b1); emit_v = 1'b1;
              end
            endcase
          end
        end
        S_SWALK: begin
          // r_r is candidate successor; q_r is predecessor (NIL = insert at head)
          if (ok(r_r) && steps_r <= (IW+1)'(NUM_TIMERS) &&
              add_sum <= {1'b0, cmd_r.delay_ticks}) begin
            total_r <= add_sum;
            q_r <= r_r;
            r_r <= link_r[ri];
            steps_r <= steps_r + 1'b1;
          end else state_r <= S_SLINK;
        end
        S_SLINK: begin
          delta_r[p_r[AW-1:0]] <= cmd_r.delay_ticks - total_r[DELTA_W-1:0];
          link_r[p_r[AW-1:0]] <= ok(r_r) ? r_r : NIL;
          if (ok(q_r)) link_r[q_r[AW-1:0]] <= p_r;
          else head_r <= p_r;
          state_r <= S_SFIX;
        end
        S_SFIX: begin
          if (ok(r_r)) begin
            if (delta_r[ri] >= delta_r[p_r[AW-1:0]])
              delta_r[ri] <= delta_r[ri] - delta_r[p_r[AW-1:0]];
            else delta_r[ri] <= '0;
          end
          res_r <= mk(ST_OK, '0, '0, 1'b1); emit_v = 1'b1;
          state_r <= S_IDLE;
        end
        S_CWALK: begin
          if (!ok(r_r) || steps_r >= (IW+1)'(NUM_TIMERS)) begin
            res_r <= mk(ST_NOTFOUND, '0, '0, 1'b1); emit_v = 1'b1;
            state_r <= S_IDLE;
          end else if (hand_r[ri] == cmd_r.callback_id && argm_r[ri] == cmd_r.callback_arg) begin
            p_r <= r_r;
            r_r <= ok(link_r[ri]) ? link_r[ri] : NIL;
            total_r <= {1'b0, delta_r[ri]};
            state_r <= S_CFIX;
          end else begin
            bef_r <= r_r;
            r_r <= link_r[ri];
            steps_r <= steps_r + 1'b1;
          end
        end
        S_CFIX: begin
          if (ok(r_r)) delta_r[ri] <= add_sum[DELTA_W] ? DMAX : add_sum[DELTA_W-1:0];
          if (ok(bef_r)) link_r[bef_r[AW-1:0]] <= r_r;
          else head_r <= r_r;
          link_r[p_r[AW-1:0]] <= free_r;
          free_r <= p_r;
          res_r <= mk(ST_OK, '0, '0, 1'b1); emit_v = 1'b1;
          state_r <= S_IDLE;
        end
        S_THEAD: begin
          if (delta_r[hi] != '0) delta_r[hi] <= delta_r[hi] - 1'b1;
          state_r <= S_TEMIT;
        end
        S_TEMIT: begin
          if (nout_r < 5'(MAX_OUT) && ok(head_r) && delta_r[hi] == '0) begin
            res_r <= mk(ST_EXPIRED, hand_r[hi], argm_r[hi],
                        !(nout_r + 1'b1 < 5'(MAX_OUT) && ok(link_r[hi]) &&
                          delta_r[link_r[hi][AW-1:0]] == '0));
            emit_v = 1'b1;
            nout_r <= nout_r + 1'b1;
            head_r <= ok(link_r[hi]) ? link_r[hi] : NIL;
            link_r[hi] <= free_r;
            free_r <= head_r;
          end else begin
            if (nout_r == '0) begin
              res_r <= mk(ST_NONE, '0, '0, 1'b1); emit_v = 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (!rst_n) ovalid_r <= 1'b0;
    else if (emit_v) ovalid_r <= 1'b1;
    else if (out_ch.ready) ovalid_r <= 1'b0;
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
  a_heads_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (head_r <= NIL && free_r <= NIL)) else $error("bad head");
endmodule
